// ----- src/c_subset_lexer_unit_assert.svh -----
// Assertion macros for the C subset lexer unit.
// Used by the port checker; needs nothing else.
`ifndef C_SUBSET_LEXER_UNIT_ASSERT_SVH
`define C_SUBSET_LEXER_UNIT_ASSERT_SVH

// clocked check, off while reset is held
`define CSL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also runs during reset
`define CSL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/csl_pkg.sv -----
// Shared types, token kinds and the keyword lookup of the C subset lexer.
// No dependencies.
`timescale 1ns / 1ps

package csl_pkg;

    localparam int PREFIX_DEPTH = 6;
    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_ERROR   = 5'd1;
    localparam logic [4:0] K_INT     = 5'd2;
    localparam logic [4:0] K_VOID    = 5'd3;
    localparam logic [4:0] K_IF      = 5'd4;
    localparam logic [4:0] K_ELSE    = 5'd5;
    localparam logic [4:0] K_WHILE   = 5'd6;
    localparam logic [4:0] K_FOR     = 5'd7;
    localparam logic [4:0] K_RETURN  = 5'd8;
    localparam logic [4:0] K_NUMBER  = 5'd9;
    localparam logic [4:0] K_IDENT   = 5'd10;
    localparam logic [4:0] K_PLUS    = 5'd11;
    localparam logic [4:0] K_MINUS   = 5'd12;
    localparam logic [4:0] K_STAR    = 5'd13;
    localparam logic [4:0] K_SLASH   = 5'd14;
    localparam logic [4:0] K_PERCENT = 5'd15;
    localparam logic [4:0] K_ASSIGN  = 5'd16;
    localparam logic [4:0] K_EQ      = 5'd17;
    localparam logic [4:0] K_NEQ     = 5'd18;
    localparam logic [4:0] K_LT      = 5'd19;
    localparam logic [4:0] K_GT      = 5'd20;
    localparam logic [4:0] K_LTE     = 5'd21;
    localparam logic [4:0] K_GTE     = 5'd22;
    localparam logic [4:0] K_AND     = 5'd23;
    localparam logic [4:0] K_OR      = 5'd24;
    localparam logic [4:0] K_NOT     = 5'd25;
    localparam logic [4:0] K_LPAREN  = 5'd26;
    localparam logic [4:0] K_RPAREN  = 5'd27;
    localparam logic [4:0] K_LBRACE  = 5'd28;
    localparam logic [4:0] K_RBRACE  = 5'd29;
    localparam logic [4:0] K_SEMI    = 5'd30;
    localparam logic [4:0] K_COMMA   = 5'd31;

    typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

    // One accepted byte: an optional token that it closes (p_*) and an
    // optional token that it starts and finishes itself (s_*).
    typedef struct packed {
        logic        p_valid;
        logic [4:0]  p_kind;
        logic [7:0]  p_len;
        logic [31:0] p_start;
        logic [31:0] p_value;
        logic        s_valid;
        logic [4:0]  s_kind;
        logic [7:0]  s_len;
        logic [31:0] s_start;
        logic [31:0] line;
    } lex_entry_t;

    function automatic logic [4:0] kw_kind(input prefix_t pfx, input logic [7:0] len);
        logic [4:0] k;
        k = K_IDENT;
        if (len == 8'd3 && pfx[0] == "i" && pfx[1] == "n" && pfx[2] == "t")
            k = K_INT;
        if (len == 8'd4 && pfx[0] == "v" && pfx[1] == "o" && pfx[2] == "i" && pfx[3] == "d")
            k = K_VOID;
        if (len == 8'd2 && pfx[0] == "i" && pfx[1] == "f")
            k = K_IF;
        if (len == 8'd4 && pfx[0] == "e" && pfx[1] == "l" && pfx[2] == "s" && pfx[3] == "e")
            k = K_ELSE;
        if (len == 8'd5 && pfx[0] == "w" && pfx[1] == "h" && pfx[2] == "i"
            && pfx[3] == "l" && pfx[4] == "e")
            k = K_WHILE;
        if (len == 8'd3 && pfx[0] == "f" && pfx[1] == "o" && pfx[2] == "r")
            k = K_FOR;
        if (len == 8'd6 && pfx[0] == "r" && pfx[1] == "e" && pfx[2] == "t"
            && pfx[3] == "u" && pfx[4] == "r" && pfx[5] == "n")
            k = K_RETURN;
        return k;
    endfunction

endpackage

// ----- src/csl_front.sv -----
// Scanner front end: one source byte per cycle while take is high,
// produces a queue entry. Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_front #(
    parameter int IDENT_LIMIT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [7:0]          source_byte,
    input  logic                end_of_input,
    output logic                push,
    output csl_pkg::lex_entry_t push_entry
);
    import csl_pkg::*;

    localparam logic [7:0] IdentMax = 8'(IDENT_LIMIT - 1);

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_IDENT      = 4'd1;
    localparam logic [3:0] M_NUMBER     = 4'd2;
    localparam logic [3:0] M_SLASH      = 4'd3;
    localparam logic [3:0] M_LINE_CMT   = 4'd4;
    localparam logic [3:0] M_BLOCK_CMT  = 4'd5;
    localparam logic [3:0] M_BLOCK_STAR = 4'd6;
    localparam logic [3:0] M_EQ         = 4'd7;
    localparam logic [3:0] M_BANG       = 4'd8;
    localparam logic [3:0] M_LT         = 4'd9;
    localparam logic [3:0] M_GT         = 4'd10;
    localparam logic [3:0] M_AMP        = 4'd11;
    localparam logic [3:0] M_BAR        = 4'd12;
    localparam logic [3:0] M_STOPPED    = 4'd13;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    logic [3:0]  mode_reg, mode_next;
    prefix_t     prefix_reg, prefix_next;
    logic [7:0]  wlen_reg, wlen_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] pstart_reg, pstart_next;

    logic        fin, is_digit, is_alpha, again, line_inc;
    logic [3:0]  dig;
    lex_entry_t  ent;

    assign fin      = end_of_input || (source_byte == 8'h00);
    assign is_digit = source_byte inside {[CH_ZERO:CH_NINE]};
    assign is_alpha = source_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
    assign dig      = 4'(source_byte - CH_ZERO);

    always_comb begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        wlen_next   = wlen_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        again       = 1'b0;
        line_inc    = 1'b0;
        ent         = '0;
        ent.line    = line_reg;
        ent.s_start = pos_reg;
        ent.p_start = pstart_reg;

        case (mode_reg)
            M_IDLE: begin
                again = 1'b1;
            end
            M_IDENT: begin
                if (!fin && (is_alpha || is_digit) && wlen_reg < IdentMax) begin
                    if (wlen_reg < 8'(PREFIX_DEPTH))
                        prefix_next[wlen_reg[2:0]] = source_byte;
                    wlen_next = wlen_reg + 8'd1;
                end else begin
                    ent.p_valid = 1'b1;
                    ent.p_kind  = kw_kind(prefix_reg, wlen_reg);
                    ent.p_len   = wlen_reg;
                    mode_next   = M_IDLE;
                    again       = 1'b1;
                end
            end
            M_NUMBER: begin
                if (!fin && is_digit) begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + 32'(dig);
                    if (wlen_reg != 8'hFF)
                        wlen_next = wlen_reg + 8'd1;
                end else begin
                    ent.p_valid = 1'b1;
                    ent.p_kind  = K_NUMBER;
                    ent.p_len   = wlen_reg;
                    ent.p_value = acc_reg;
                    mode_next   = M_IDLE;
                    again       = 1'b1;
                end
            end
            M_SLASH: begin
                if (!fin && source_byte == CH_SLASH) begin
                    mode_next = M_LINE_CMT;
                end else if (!fin && source_byte == CH_STAR) begin
                    mode_next = M_BLOCK_CMT;
                end else begin
                    ent.p_valid = 1'b1;
                    ent.p_kind  = K_SLASH;
                    ent.p_len   = 8'd1;
                    mode_next   = M_IDLE;
                    again       = 1'b1;
                end
            end
            M_EQ, M_BANG, M_LT, M_GT: begin
                mode_next   = M_IDLE;
                ent.p_valid = 1'b1;
                if (!fin && source_byte == CH_EQ) begin
                    ent.p_len = 8'd2;
                    case (mode_reg)
                        M_EQ:    ent.p_kind = K_EQ;
                        M_BANG:  ent.p_kind = K_NEQ;
                        M_LT:    ent.p_kind = K_LTE;
                        default: ent.p_kind = K_GTE;
                    endcase
                end else begin
                    ent.p_len = 8'd1;
                    again     = 1'b1;
                    case (mode_reg)
                        M_EQ:    ent.p_kind = K_ASSIGN;
                        M_BANG:  ent.p_kind = K_NOT;
                        M_LT:    ent.p_kind = K_LT;
                        default: ent.p_kind = K_GT;
                    endcase
                end
            end
            M_AMP, M_BAR: begin
                ent.p_valid = 1'b1;
                if (!fin && source_byte == ((mode_reg == M_AMP) ? CH_AMP : CH_BAR)) begin
                    ent.p_kind = (mode_reg == M_AMP) ? K_AND : K_OR;
                    ent.p_len  = 8'd2;
                    mode_next  = M_IDLE;
                end else begin
                    // lone & or |: error, the current byte is dropped
                    ent.p_kind = K_ERROR;
                    ent.p_len  = 8'd1;
                    mode_next  = M_STOPPED;
                end
            end
            M_LINE_CMT: begin
                if (fin) begin
                    mode_next = M_IDLE;
                    again     = 1'b1;
                end else if (source_byte == CH_NL) begin
                    line_inc  = 1'b1;
                    mode_next = M_IDLE;
                end
            end
            M_BLOCK_CMT, M_BLOCK_STAR: begin
                if (fin) begin
                    mode_next = M_IDLE;
                    again     = 1'b1;
                end else if (source_byte == CH_SLASH && mode_reg == M_BLOCK_STAR) begin
                    mode_next = M_IDLE;
                end else begin
                    line_inc  = (source_byte == CH_NL);
                    mode_next = (source_byte == CH_STAR) ? M_BLOCK_STAR : M_BLOCK_CMT;
                end
            end
            M_STOPPED: begin
            end
            default: begin
                mode_next = M_IDLE;
                again     = 1'b1;
            end
        endcase

        if (again) begin
            if (fin) begin
                ent.s_valid = 1'b1;
                ent.s_kind  = K_EOF;
                ent.s_len   = 8'd0;
                mode_next   = M_STOPPED;
            end else begin
                pstart_next = pos_reg;
                ent.s_len   = 8'd1;
                case (source_byte)
                    CH_SPACE, CH_TAB, CH_CR: begin
                    end
                    CH_NL:    line_inc  = 1'b1;
                    CH_SLASH: mode_next = M_SLASH;
                    CH_EQ:    mode_next = M_EQ;
                    CH_BANG:  mode_next = M_BANG;
                    CH_LT:    mode_next = M_LT;
                    CH_GT:    mode_next = M_GT;
                    CH_AMP:   mode_next = M_AMP;
                    CH_BAR:   mode_next = M_BAR;
                    CH_LPAR:  begin ent.s_valid = 1'b1; ent.s_kind = K_LPAREN;  end
                    CH_RPAR:  begin ent.s_valid = 1'b1; ent.s_kind = K_RPAREN;  end
                    CH_LBRC:  begin ent.s_valid = 1'b1; ent.s_kind = K_LBRACE;  end
                    CH_RBRC:  begin ent.s_valid = 1'b1; ent.s_kind = K_RBRACE;  end
                    CH_SEMI:  begin ent.s_valid = 1'b1; ent.s_kind = K_SEMI;    end
                    CH_COMMA: begin ent.s_valid = 1'b1; ent.s_kind = K_COMMA;   end
                    CH_PLUS:  begin ent.s_valid = 1'b1; ent.s_kind = K_PLUS;    end
                    CH_MINUS: begin ent.s_valid = 1'b1; ent.s_kind = K_MINUS;   end
                    CH_STAR:  begin ent.s_valid = 1'b1; ent.s_kind = K_STAR;    end
                    CH_PCT:   begin ent.s_valid = 1'b1; ent.s_kind = K_PERCENT; end
                    default: begin
                        if (is_digit) begin
                            mode_next = M_NUMBER;
                            acc_next  = 32'(dig);
                            wlen_next = 8'd1;
                        end else if (is_alpha) begin
                            mode_next     = M_IDENT;
                            prefix_next[0] = source_byte;
                            wlen_next     = 8'd1;
                        end else begin
                            ent.s_valid = 1'b1;
                            ent.s_kind  = K_ERROR;
                            mode_next   = M_STOPPED;
                        end
                    end
                endcase
            end
        end

        if (line_inc && line_reg != 32'hFFFF_FFFF)
            line_next = line_reg + 32'd1;
        if (!fin && mode_reg != M_STOPPED)
            pos_next = pos_reg + 32'd1;
    end

    assign push       = take && (ent.p_valid || ent.s_valid);
    assign push_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            wlen_reg   <= 8'd0;
            acc_reg    <= 32'd0;
            line_reg   <= 32'd1;
            pos_reg    <= 32'd0;
            pstart_reg <= 32'd0;
        end else if (take) begin
            mode_reg   <= mode_next;
            wlen_reg   <= wlen_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
        end
    end

    // identifier prefix: only entries below the word length are read
    always_ff @(posedge aclk) begin
        if (take)
            prefix_reg <= prefix_next;
    end

endmodule

// ----- src/csl_queue.sv -----
// Short queue of scanned entries between the scanner and the token emitter.
// Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  csl_pkg::lex_entry_t push_entry,
    input  logic                pop,
    output csl_pkg::lex_entry_t head,
    output logic                empty,
    output logic                not_full
);
    import csl_pkg::*;

    lex_entry_t     slot_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next;
    logic [QAW-1:0] rptr_reg, rptr_next;
    logic [QAW:0]   cnt_reg, cnt_next;

    assign head     = slot_reg[rptr_reg];
    assign empty    = (cnt_reg == '0);
    assign not_full = (cnt_reg != (QAW+1)'(QDEPTH));

    always_comb begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wptr_reg] <= push_entry;
    end

endmodule

// ----- src/csl_back.sv -----
// Token emitter: splits each queue entry into one or two output tokens
// and holds them in the output register. Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  csl_pkg::lex_entry_t head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [4:0]          m_token_kind,
    output logic [31:0]         m_line_number,
    output logic signed [31:0]  m_number_value,
    output logic [31:0]         m_token_start,
    output logic [7:0]          m_token_length,
    output logic                m_last_of_run
);
    import csl_pkg::*;

    logic        valid_reg, valid_next;
    logic        sel_reg, sel_next;  // 1: closing token already sent
    logic [4:0]  kind_reg;
    logic [31:0] line_reg, value_reg, start_reg;
    logic [7:0]  len_reg;
    logic        last_reg;

    logic        load, use_p, last;

    assign load  = !empty && (!valid_reg || m_ready);
    assign use_p = !sel_reg && head.p_valid;
    assign last  = use_p ? !head.s_valid : 1'b1;
    assign pop   = load && last;

    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load) begin
            valid_next = 1'b1;
            sel_next   = !last;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= use_p ? head.p_kind : head.s_kind;
            len_reg   <= use_p ? head.p_len : head.s_len;
            start_reg <= use_p ? head.p_start : head.s_start;
            value_reg <= use_p ? head.p_value : 32'd0;
            line_reg  <= head.line;
            last_reg  <= last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = kind_reg;
    assign m_line_number  = line_reg;
    assign m_number_value = $signed(value_reg);
    assign m_token_start  = start_reg;
    assign m_token_length = len_reg;
    assign m_last_of_run  = last_reg;

endmodule

// ----- src/c_subset_lexer_unit.sv -----
// Streaming lexer for a small C subset: one source byte per cycle in while
// s_ready is high, up to two tokens per byte out. A token passes through a queue
// slot, then the output register, after the byte that completes it; the second
// token of a byte follows the first. Throughput: one byte per cycle while
// s_ready is high, one token per cycle while m_ready is high; a byte that
// yields two tokens uses the output twice, the 4-entry queue absorbs it.
// Reset: synchronous active-low aresetn returns to line 1, offset 0, queue empty.
`timescale 1ns / 1ps

module c_subset_lexer_unit #(
    parameter int IDENT_LIMIT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_source_byte,
    input  logic               s_end_of_input,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_token_kind,
    output logic [31:0]        m_line_number,
    output logic signed [31:0] m_number_value,
    output logic [31:0]        m_token_start,
    output logic [7:0]         m_token_length,
    output logic               m_last_of_run
);
    import csl_pkg::*;

    logic       take, push, pop, q_empty, q_not_full;
    lex_entry_t push_entry, head;

    assign s_ready = q_not_full;
    assign take    = s_valid && s_ready;

    csl_front #(
        .IDENT_LIMIT(IDENT_LIMIT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .source_byte (s_source_byte),
        .end_of_input(s_end_of_input),
        .push        (push),
        .push_entry  (push_entry)
    );

    csl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .not_full  (q_not_full)
    );

    csl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_line_number (m_line_number),
        .m_number_value(m_number_value),
        .m_token_start (m_token_start),
        .m_token_length(m_token_length),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ----- src/csl_checker.sv -----
// Port-level checks for the C subset lexer unit, bound to the top level.
// Depends on csl_pkg and c_subset_lexer_unit_assert.svh.
`timescale 1ns / 1ps
`include "c_subset_lexer_unit_assert.svh"

module csl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_token_kind,
    input logic       m_last_of_run
);
    import csl_pkg::*;

    logic fire, stop_tok;

    assign fire     = m_valid && m_ready;
    assign stop_tok = (m_token_kind == K_EOF) || (m_token_kind == K_ERROR);

    // reset empties the output
    `CSL_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> !m_valid, "output valid after reset")

    // a stalled item stays offered
    `CSL_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "item dropped")

    // the second token of a byte follows right after the first
    `CSL_ASSERT(a_pair, aclk, aresetn, fire && !m_last_of_run |=> m_valid, "pair broken")

    // nothing comes after end of file or an error
    `CSL_ASSERT(a_stop, aclk, aresetn, fire && stop_tok |=> !m_valid, "token after stop")

endmodule

bind c_subset_lexer_unit csl_checker u_csl_checker (.*);
